/* rtl/cjk_line_break_segmenter_defines.svh */
// ============================================================================
// Assertion macros for the line break segmenter
// Concurrent assertion wrappers, clocked on clk and disabled during reset.
// ============================================================================
`ifndef CJK_LINE_BREAK_SEGMENTER_DEFINES_SVH
`define CJK_LINE_BREAK_SEGMENTER_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that cons holds in the same cycle as ante.
`define CJLS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that cons holds in the cycle after ante.
`define CJLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CJLS_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CJLS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/cjls_pkg.sv */
// ============================================================================
// Line break segmenter package
// Character classes, job and status records, and the classification tables.
// ============================================================================
package cjls_pkg;

    localparam int CP_W             = 21;
    localparam int LEN_W            = 8;
    localparam int DATA_W           = 24;
    localparam int CJLS_QUEUE_DEPTH = 4;

    localparam logic [LEN_W-1:0] SPLIT_LEN_RESET = 8'd24;
    localparam logic [2:0]       ADDR_SPLIT_LEN  = 3'd0;

    typedef logic [CP_W-1:0] cp_t;

    typedef enum logic [2:0]
    {
        CLS_WS,
        CLS_NS,
        CLS_NE,
        CLS_ID,
        CLS_OT
    } cls_t;

    // One character to be processed by the back end, with the class of the
    // character that follows it.
    typedef struct packed
    {
        cp_t  cp;
        cls_t cls;
        cls_t next_cls;
        logic has_next;
        logic is_last;
    } job_t;

    typedef struct packed
    {
        logic             word_open;
        logic             only_openers;
        logic [LEN_W-1:0] word_length;
    } word_stat_t;

    localparam cp_t CP_SPACE      = 21'h00020;
    localparam cp_t CP_IDEO_SPACE = 21'h03000;
    localparam cp_t CP_NBSP       = 21'h000A0;
    localparam cp_t CP_ZWSP       = 21'h0200B;

    localparam int NS_N = 52;
    localparam int NE_N = 27;
    localparam int ID_N = 20;

    localparam cp_t NS_TAB [NS_N] = '{
        21'hFF0C, 21'h3001, 21'h3002, 21'hFF0E, 21'hFF1B, 21'hFF1A, 21'hFF01, 21'hFF1F,
        21'hFF09, 21'h3011, 21'h300B, 21'h300D, 21'h300F, 21'h3015,
        21'h3017, 21'h3019, 21'h301B, 21'hFF5D, 21'hFF3D, 21'hFF60, 21'h3009,
        21'h201D, 21'h2019, 21'h00BB, 21'h203A,
        21'h2026, 21'h2014, 21'h2013, 21'hFF5E, 21'h00B7, 21'h2022,
        21'h00B0, 21'h0025, 21'h2030, 21'h2103, 21'h2109,
        21'h29, 21'h5D, 21'h7D, 21'h3E, 21'h2C, 21'h2E, 21'h3B, 21'h3A, 21'h21, 21'h3F,
        21'h2F, 21'h5C, 21'h7C, 21'h2D, 21'h5F, 21'h7E
    };

    localparam cp_t NE_TAB [NE_N] = '{
        21'hFF08, 21'h3010, 21'h300A, 21'h300C, 21'h300E, 21'h3014,
        21'h3016, 21'h3018, 21'h301A, 21'hFF5B, 21'hFF3B, 21'hFF5F, 21'h3008,
        21'h201C, 21'h2018, 21'h00AB, 21'h2039,
        21'h00A5, 21'h0024, 21'h00A3, 21'h20AC, 21'h2116, 21'h00A7,
        21'h28, 21'h5B, 21'h7B, 21'h3C
    };

    localparam cp_t ID_LO [ID_N] = '{
        21'h4E00, 21'h3400, 21'h20000, 21'h30000, 21'hF900, 21'h2F800,
        21'h3040, 21'h30A0, 21'h3100, 21'h31A0, 21'h31F0, 21'h3200,
        21'h3300, 21'hAC00, 21'h1100, 21'h3130, 21'h2E80, 21'h2460,
        21'h2500, 21'h2600
    };

    localparam cp_t ID_HI [ID_N] = '{
        21'h9FFF, 21'h4DBF, 21'h2EBEF, 21'h3134F, 21'hFAFF, 21'h2FA1F,
        21'h309F, 21'h30FF, 21'h312F, 21'h31BF, 21'h31FF, 21'h32FF,
        21'h33FF, 21'hD7AF, 21'h11FF, 21'h318F, 21'h2FDF, 21'h24FF,
        21'h25FF, 21'h27BF
    };

    function automatic cls_t cjls_classify(input cp_t c);
        logic ws_hit;
        logic ns_hit;
        logic ne_hit;
        logic id_hit;
        cls_t cls;
        ws_hit = (c == CP_SPACE) || (c >= 21'h09 && c <= 21'h0D) || (c == CP_NBSP) ||
                 (c == CP_IDEO_SPACE) || (c >= 21'h2000 && c <= CP_ZWSP);
        ns_hit = 1'b0;
        ne_hit = 1'b0;
        id_hit = 1'b0;
        for (int i = 0; i < NS_N; i++)
        begin
            if (c == NS_TAB[i])
                ns_hit = 1'b1;
        end
        for (int i = 0; i < NE_N; i++)
        begin
            if (c == NE_TAB[i])
                ne_hit = 1'b1;
        end
        for (int i = 0; i < ID_N; i++)
        begin
            if (c >= ID_LO[i] && c <= ID_HI[i])
                id_hit = 1'b1;
        end
        if (ws_hit)
            cls = CLS_WS;
        else if (ns_hit)
            cls = CLS_NS;
        else if (ne_hit)
            cls = CLS_NE;
        else if (id_hit)
            cls = CLS_ID;
        else
            cls = CLS_OT;
        return cls;
    endfunction

endpackage

/* rtl/cjls_front.sv */
// ============================================================================
// Segmenter front end
// Classifies each incoming code point, keeps one character of look-ahead and
// turns every accepted beat into zero, one or two jobs for the queue.
// ============================================================================
module cjls_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cjls_pkg::cp_t       in_cp,
    input  logic                in_last,
    input  logic                q_room,
    output logic [1:0]          push_count,
    output cjls_pkg::job_t      push_a,
    output cjls_pkg::job_t      push_b,
    output logic                held_valid
);
    import cjls_pkg::*;

    cp_t  held_char_reg;
    cp_t  held_char_next;
    cls_t held_cls_reg;
    cls_t held_cls_next;
    logic held_valid_reg;
    logic held_valid_next;
    cls_t cur_cls;
    logic accept;
    job_t held_job;
    job_t cur_job;

    assign cur_cls  = cjls_classify(in_cp);
    assign s_tready = q_room;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        held_job.cp       = held_char_reg;
        held_job.cls      = held_cls_reg;
        held_job.next_cls = cur_cls;
        held_job.has_next = 1'b1;
        held_job.is_last  = 1'b0;

        cur_job.cp        = in_cp;
        cur_job.cls       = cur_cls;
        cur_job.next_cls  = CLS_OT;
        cur_job.has_next  = 1'b0;
        cur_job.is_last   = 1'b1;

        // The held character always goes first; the new one only follows it
        // when it ends the text.
        push_a = held_valid_reg ? held_job : cur_job;
        push_b = cur_job;
        if (accept)
            push_count = {1'b0, held_valid_reg} + {1'b0, in_last};
        else
            push_count = 2'd0;

        held_char_next  = held_char_reg;
        held_cls_next   = held_cls_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            if (in_last)
            begin
                held_char_next  = '0;
                held_cls_next   = CLS_WS;
                held_valid_next = 1'b0;
            end
            else
            begin
                held_char_next  = in_cp;
                held_cls_next   = cur_cls;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_char_reg <= held_char_next;
        held_cls_reg  <= held_cls_next;
    end

    assign held_valid = held_valid_reg;

endmodule

/* rtl/cjls_queue.sv */
// ============================================================================
// Segmenter job queue
// Small circular queue that takes up to two jobs and gives one job per cycle when popped.
// ============================================================================
module cjls_queue
#(
    parameter int DEPTH = cjls_pkg::CJLS_QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push_count,
    input  cjls_pkg::job_t  push_a,
    input  cjls_pkg::job_t  push_b,
    output logic            room,
    input  logic            pop,
    output logic            not_empty,
    output cjls_pkg::job_t  head
);
    import cjls_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
    assign room         = count_reg <= CNT_W'(DEPTH - 2);
    assign not_empty    = count_reg != '0;
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        case (push_count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            slot_reg[wr_ptr_reg] <= push_a;
        if (push_count == 2'd2)
            slot_reg[wr_ptr_plus1] <= push_b;
    end

endmodule

/* rtl/cjls_back.sv */
// ============================================================================
// Segmenter back end
// Applies the line break rules to one job per cycle while the output is not
// stalled, tracks the pending word and drives the registered output beat.
// ============================================================================
module cjls_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  cjls_pkg::job_t                 job,
    output logic                           pop,
    input  logic [cjls_pkg::LEN_W-1:0]     split_len,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output cjls_pkg::cp_t                  out_cp,
    output logic                           out_space,
    output logic                           out_word_end,
    output logic                           out_last,
    output cjls_pkg::word_stat_t           word_stat
);
    import cjls_pkg::*;

    word_stat_t       stat_reg;
    word_stat_t       stat_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    cp_t              cp_reg;
    cp_t              cp_next;
    logic             space_reg;
    logic             space_next;
    logic             wend_reg;
    logic             wend_next;
    logic             last_reg;
    logic             cut;

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '1)
            r = v;
        else
            r = v + 1'b1;
        return r;
    endfunction

    assign pop = job_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        stat_next  = stat_reg;
        cp_next    = job.cp;
        space_next = 1'b0;
        wend_next  = 1'b0;
        cut        = 1'b0;

        case (job.cls)
            CLS_WS:
            begin
                stat_next  = '{word_open: 1'b0, only_openers: 1'b1, word_length: '0};
                space_next = 1'b1;
                if (job.cp inside {CP_IDEO_SPACE, CP_NBSP, CP_ZWSP})
                    cp_next = CP_SPACE;
            end
            CLS_NS:
            begin
                stat_next.word_open    = 1'b1;
                stat_next.word_length  = sat_inc(stat_reg.word_length);
                stat_next.only_openers = 1'b0;
                cut = job.has_next && job.next_cls != CLS_NS;
            end
            CLS_NE:
            begin
                stat_next = '{word_open: 1'b1, only_openers: 1'b1, word_length: LEN_W'(1)};
            end
            CLS_ID:
            begin
                // An ideograph joins the pending word only if that word holds
                // nothing but opening punctuation.
                stat_next.word_open    = 1'b1;
                stat_next.only_openers = 1'b0;
                if (stat_reg.word_open && stat_reg.only_openers)
                    stat_next.word_length = sat_inc(stat_reg.word_length);
                else
                    stat_next.word_length = LEN_W'(1);
                cut = job.has_next && job.next_cls != CLS_NS;
            end
            default:
            begin
                stat_next.word_open    = 1'b1;
                stat_next.word_length  = sat_inc(stat_reg.word_length);
                stat_next.only_openers = 1'b0;
                cut = (stat_next.word_length >= split_len) && job.has_next &&
                      job.next_cls != CLS_NS;
            end
        endcase

        if (job.cls != CLS_WS)
        begin
            if (cut)
            begin
                wend_next = 1'b1;
                stat_next = '{word_open: 1'b0, only_openers: 1'b1, word_length: '0};
            end
            else if (!job.has_next)
            begin
                wend_next = 1'b1;
            end
            else if (job.next_cls == CLS_WS || job.next_cls == CLS_NE ||
                     (job.next_cls == CLS_ID && !stat_next.only_openers))
            begin
                wend_next = 1'b1;
            end
        end

        if (job.is_last)
            stat_next = '{word_open: 1'b0, only_openers: 1'b1, word_length: '0};

        if (pop)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg      <= '{word_open: 1'b0, only_openers: 1'b1, word_length: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
                stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cp_reg    <= cp_next;
            space_reg <= space_next;
            wend_reg  <= wend_next;
            last_reg  <= job.is_last;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign out_cp       = cp_reg;
    assign out_space    = space_reg;
    assign out_word_end = wend_reg;
    assign out_last     = last_reg;
    assign word_stat    = stat_reg;

endmodule

/* rtl/cjk_line_break_segmenter.sv */
// Line break opportunity marker for CJK and Latin text. Code points enter one
// beat per cycle while the queue has room and leave one beat per cycle while
// m_tready is high, each marked as a space unit or as the end of a word unit.
// The block holds back one character to see the next one, so a beat other than
// the last leaves only after the character that follows it arrives. A beat with
// s_tlast set releases both the held character and its own through the
// single-beat output stage of the back end.
// ============================================================================
// Line break segmenter top level
// Front end classifier, job queue, rule back end and the APB register.
// ============================================================================
`include "cjk_line_break_segmenter_defines.svh"

module cjk_line_break_segmenter
#(
    parameter int QUEUE_DEPTH = cjls_pkg::CJLS_QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // APB register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cjls_pkg::DATA_W-1:0]   s_tdata,   // [20:0] code_point
    input  logic                          s_tlast,   // end_of_text
    // Output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cjls_pkg::DATA_W-1:0]   m_tdata,   // [20:0] char_out
    output logic [1:0]                    m_tuser,   // [0] is_space, [1] word_end
    output logic                          m_tlast    // last
);
    import cjls_pkg::*;

    logic [LEN_W-1:0] split_len_reg;
    logic             cfg_write;
    logic             q_room;
    logic [1:0]       push_count;
    job_t             push_a;
    job_t             push_b;
    logic             pop;
    logic             q_not_empty;
    job_t             q_head;
    logic             held_valid;
    word_stat_t       word_stat;
    cp_t              out_cp;
    logic             out_space;
    logic             out_word_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_SPLIT_LEN);
    assign prdata    = (paddr == ADDR_SPLIT_LEN) ? {{(32 - LEN_W){1'b0}}, split_len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_len_reg <= SPLIT_LEN_RESET;
        end
        else if (cfg_write)
        begin
            split_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    cjls_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_cp      (s_tdata[CP_W-1:0]),
        .in_last    (s_tlast),
        .q_room     (q_room),
        .push_count (push_count),
        .push_a     (push_a),
        .push_b     (push_b),
        .held_valid (held_valid)
    );

    cjls_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_a     (push_a),
        .push_b     (push_b),
        .room       (q_room),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    cjls_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_not_empty),
        .job          (q_head),
        .pop          (pop),
        .split_len    (split_len_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_cp       (out_cp),
        .out_space    (out_space),
        .out_word_end (out_word_end),
        .out_last     (m_tlast),
        .word_stat    (word_stat)
    );

    assign m_tdata = {{(DATA_W - CP_W){1'b0}}, out_cp};
    assign m_tuser = {out_word_end, out_space};

    // The beat that ends a text leaves the word tracker in its idle state.
    `CJLS_ASSERT_IMPLY(a_last_clears_word, m_tvalid && m_tlast, !word_stat.word_open && word_stat.word_length == '0, "word state not cleared at end of text")
    // A space unit never closes a word.
    `CJLS_ASSERT_IMPLY(a_space_no_word_end, m_tvalid, !(m_tuser[0] && m_tuser[1]), "space beat marked as word end")
    // Nothing stays held once the end of a text has been taken.
    `CJLS_ASSERT_NEXT(a_eot_drops_held, s_tvalid && s_tready && s_tlast, !held_valid, "character still held after end of text")

endmodule
